// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define CHK_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/swm_pkg.sv =====
// Shared constants and types of the sliding-window statistics block.
package swm_pkg;

	localparam int CFG_W = 5;
	localparam int CNT_W = 5;
	localparam logic [CFG_W-1:0] SIZE_RESET = 5'd12;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== design/swm_ifs.sv =====
// Channel interfaces: sample input, statistics output, window size write.
interface swm_sample_if #(parameter int SAMPLE_BITS = 10);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] wind_speed;
	modport source (output valid, output wind_speed, input ready);
	modport sink   (input valid, input wind_speed, output ready);
endinterface

interface swm_stats_if #(parameter int SAMPLE_BITS = 10);
	logic                     valid;
	logic                     ready;
	logic [SAMPLE_BITS-1:0]   max_speed;
	logic [SAMPLE_BITS-1:0]   min_speed;
	logic [SAMPLE_BITS-1:0]   avg_speed;
	logic [swm_pkg::CNT_W-1:0] held_count;
	modport source (output valid, output max_speed, output min_speed, output avg_speed,
		output held_count, input ready);
	modport sink   (input valid, input max_speed, input min_speed, input avg_speed,
		input held_count, output ready);
endinterface

interface swm_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [swm_pkg::CFG_W-1:0] window_size;
	modport source (output valid, output window_size, input ready);
	modport sink   (input valid, input window_size, output ready);
endinterface

// ===== design/swm_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module swm_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/swm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module swm_div #(
	parameter int DW = 16,
	parameter int VW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DW-1:0]        dividend,
	input  logic [VW-1:0]        divisor,
	output swm_pkg::div_status_t status,
	output logic [DW-1:0]        quotient
);
	import swm_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          take;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, divisor};
	assign take  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			// remainder stays below divisor, so the low VW bits suffice
			rem_q <= take ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], take};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

// ===== design/sliding_window_min_max_avg_top.sv =====
// Sliding-window min, max and mean over wind speed samples, ring kept in a RAM.
//
//  channel    | dir | payload                                        | ready
//  -----------+-----+------------------------------------------------+--------------
//  sample_in  | in  | wind_speed                                     | idle only
//  stats_out  | out | max_speed, min_speed, avg_speed, held_count    | from sink
//  cfg        | in  | window_size                                    | always high
//
// One sample at a time: accept, old-entry read when full, store, ring walk through the
// RAM read port, serial divide, finish. The result sits in an output register; a stalled
// sink holds it and blocks only the finish step. Reset sets window size 12 and an empty
// window; RAM needs no clearing.
module sliding_window_min_max_avg_top #(
	parameter int MAX_WINDOW  = 16,
	parameter int SAMPLE_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	swm_sample_if.sink   sample_in,
	swm_stats_if.source  stats_out,
	swm_cfg_if.sink      cfg
);
	import swm_pkg::*;

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int DW    = SUM_W + 1;
	localparam int VW    = CNT_W + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RDOLD = 3'd1;
	localparam logic [2:0] S_STORE = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	function automatic logic [CNT_W-1:0] ring_next(input logic [CNT_W-1:0] pos,
		input logic [CNT_W-1:0] ws);
		logic [CNT_W:0] n;
		n = {1'b0, pos} + (CNT_W+1)'(1);
		ring_next = (n >= {1'b0, ws}) ? '0 : n[CNT_W-1:0];
	endfunction

	logic [2:0]             state_q;
	logic [CFG_W-1:0]       ws_q;
	logic [CNT_W-1:0]       oldest_q;
	logic [CNT_W-1:0]       fill_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [CNT_W-1:0]       slot_q;
	logic                   full_q;
	logic [CNT_W-1:0]       k_q;
	logic [CNT_W-1:0]       ptr_q;
	logic                   pend_q;
	logic [SAMPLE_BITS-1:0] hi_q;
	logic [SAMPLE_BITS-1:0] lo_q;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [CNT_W-1:0]       held_q;

	logic [CNT_W-1:0]       wsize;
	logic [CNT_W-1:0]       oldest_c;
	logic [CNT_W-1:0]       fill_c;
	logic                   full_c;
	logic [CNT_W:0]         pos_sum;
	logic [CNT_W-1:0]       slot_c;

	logic                   ram_we;
	logic [AW-1:0]          ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	logic                   div_start;
	logic [DW-1:0]          div_quo;
	div_status_t            div_st;

	logic                   in_xfer;
	logic                   walk_end;
	logic                   load_out;

	// zero acts as one, oversize saturates
	always_comb begin
		if (ws_q == '0) begin
			wsize = CNT_W'(1);
		end else if (int'(ws_q) > MAX_WINDOW) begin
			wsize = CNT_W'(MAX_WINDOW);
		end else begin
			wsize = ws_q;
		end
	end

	always_comb begin
		oldest_c = (oldest_q >= wsize) ? '0 : oldest_q;
		fill_c   = (fill_q > wsize) ? wsize : fill_q;
		full_c   = (fill_c == wsize);
		pos_sum  = {1'b0, oldest_c} + {1'b0, fill_c};
		if (pos_sum >= {1'b0, wsize}) begin
			pos_sum = pos_sum - {1'b0, wsize};
		end
		slot_c = full_c ? oldest_c : pos_sum[CNT_W-1:0];
	end

	assign in_xfer         = sample_in.valid && sample_in.ready;
	assign sample_in.ready = (state_q == S_IDLE) && !div_st.busy;
	assign cfg.ready       = 1'b1;
	assign walk_end        = (state_q == S_WALK) && (k_q == fill_q) && !pend_q;
	assign div_start       = walk_end;
	assign load_out        = (state_q == S_FIN) && (!out_valid_q || stats_out.ready);
	assign ram_we          = (state_q == S_STORE);
	assign ram_raddr       = (state_q == S_RDOLD) ? AW'(slot_q) : AW'(ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ws_q        <= SIZE_RESET;
			oldest_q    <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			k_q         <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (stats_out.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.valid && cfg.ready) begin
				ws_q     <= cfg.window_size;
				oldest_q <= '0;
				fill_q   <= '0;
				sum_q    <= '0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (in_xfer) begin
							if (full_c) begin
								oldest_q <= ring_next(oldest_c, wsize);
								fill_q   <= fill_c;
								state_q  <= S_RDOLD;
							end else begin
								oldest_q <= oldest_c;
								fill_q   <= fill_c + CNT_W'(1);
								state_q  <= S_STORE;
							end
						end
					end
					S_RDOLD: begin
						state_q <= S_STORE;
					end
					S_STORE: begin
						// read data holds the dropped entry when the window was full
						sum_q   <= sum_q - (full_q ? SUM_W'(ram_rdata) : '0)
							+ SUM_W'(sample_q);
						k_q     <= '0;
						pend_q  <= 1'b0;
						state_q <= S_WALK;
					end
					S_WALK: begin
						pend_q <= (k_q != fill_q);
						if (k_q != fill_q) begin
							k_q <= k_q + CNT_W'(1);
						end
						if (walk_end) begin
							state_q <= S_DIV;
						end
					end
					S_DIV: begin
						if (div_st.done) begin
							state_q <= S_FIN;
						end
					end
					S_FIN: begin
						if (load_out) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= sample_in.wind_speed;
			slot_q   <= slot_c;
			full_q   <= full_c;
		end
		if (state_q == S_STORE) begin
			ptr_q <= oldest_q;
			hi_q  <= sample_q;
			lo_q  <= sample_q;
		end else if (state_q == S_WALK) begin
			if (k_q != fill_q) begin
				ptr_q <= ring_next(ptr_q, wsize);
			end
			if (pend_q) begin
				if (ram_rdata > hi_q) begin
					hi_q <= ram_rdata;
				end
				if (ram_rdata < lo_q) begin
					lo_q <= ram_rdata;
				end
			end
		end
		if (load_out) begin
			max_q  <= hi_q;
			min_q  <= lo_q;
			avg_q  <= div_quo[SAMPLE_BITS-1:0];
			held_q <= fill_q;
		end
	end

	swm_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WINDOW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(slot_q)),
		.wdata(sample_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// mean rounded half up: (2*sum + n) / (2*n)
	swm_div #(
		.DW(DW),
		.VW(VW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({sum_q, 1'b0} + DW'(fill_q)),
		.divisor ({fill_q, 1'b0}),
		.status  (div_st),
		.quotient(div_quo)
	);

	assign stats_out.valid      = out_valid_q;
	assign stats_out.max_speed  = max_q;
	assign stats_out.min_speed  = min_q;
	assign stats_out.avg_speed  = avg_q;
	assign stats_out.held_count = held_q;

endmodule

// ===== design/swm_checker.sv =====
// Port-level checks on the statistics output, bound to the top level.
`include "assert_macros.svh"

module swm_checker #(
	parameter int SAMPLE_BITS = 10
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [SAMPLE_BITS-1:0]    max_speed,
	input logic [SAMPLE_BITS-1:0]    min_speed,
	input logic [SAMPLE_BITS-1:0]    avg_speed,
	input logic [swm_pkg::CNT_W-1:0] held_count
);
	import swm_pkg::*;

	`CHK_IMPLY(a_held_nonzero, out_valid, held_count != '0, "result with empty window")
	`CHK_IMPLY(a_min_le_max, out_valid, min_speed <= max_speed, "min above max")
	`CHK_IMPLY(a_avg_in_range, out_valid, (avg_speed >= min_speed) && (avg_speed <= max_speed), "mean outside min..max")
	`CHK_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(max_speed) && $stable(min_speed) && $stable(avg_speed) && $stable(held_count), "stalled result changed")

endmodule

bind sliding_window_min_max_avg_top swm_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_swm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (stats_out.valid),
	.out_ready (stats_out.ready),
	.max_speed (stats_out.max_speed),
	.min_speed (stats_out.min_speed),
	.avg_speed (stats_out.avg_speed),
	.held_count(stats_out.held_count)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the sliding-window wind speed min, max and mean block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS = 10;
	localparam int MAX_WINDOW  = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 1300;

	typedef logic [SAMPLE_BITS-1:0]     speed_t;
	typedef logic [swm_pkg::CFG_W-1:0]  wsize_t;

	typedef struct {
		speed_t                    max_speed;
		speed_t                    min_speed;
		speed_t                    avg_speed;
		logic [swm_pkg::CNT_W-1:0] held_count;
	} wind_stats_t;

	// Running window statistics, one expected result per sample transfer.
	class wind_window_stats;
		speed_t         ring [MAX_WINDOW];
		int unsigned    head;
		int unsigned    fill;
		int unsigned    total;
		wsize_t         size_reg;
		wind_stats_t    due_q [$];
		int unsigned    errors;
		int unsigned    checked;

		function new();
			size_reg = swm_pkg::SIZE_RESET;
			head = 0;
			fill = 0;
			total = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_window(wsize_t v);
			size_reg = v;
			head = 0;
			fill = 0;
			total = 0;
		endfunction

		function int unsigned span();
			if (size_reg == 0)
				return 1;
			if (size_reg > MAX_WINDOW)
				return MAX_WINDOW;
			return size_reg;
		endfunction

		function void take_sample(speed_t s);
			int unsigned w;
			int unsigned slot;
			int unsigned k;
			speed_t      hi;
			speed_t      lo;
			speed_t      v;
			wind_stats_t e;
			w = span();
			if (head >= w)
				head = 0;
			if (fill > w)
				fill = w;
			if (fill < w) begin
				slot = (head + fill) % w;
				fill++;
			end else begin
				// full: oldest leaves before the new sample lands
				slot = head;
				total -= ring[slot];
				head = (head + 1) % w;
			end
			ring[slot] = s;
			total += s;
			hi = s;
			lo = s;
			for (k = 0; k < fill; k++) begin
				v = ring[(head + k) % w];
				if (v > hi)
					hi = v;
				if (v < lo)
					lo = v;
			end
			e.max_speed = hi;
			e.min_speed = lo;
			e.avg_speed = speed_t'((2 * total + fill) / (2 * fill));
			e.held_count = (swm_pkg::CNT_W)'(fill);
			due_q.insert(due_q.size(), e);
		endfunction

		function void check_stats(wind_stats_t got);
			wind_stats_t e;
			if (due_q.size() == 0) begin
				$error("unexpected stats transfer: max %0d min %0d avg %0d count %0d",
					got.max_speed, got.min_speed, got.avg_speed, got.held_count);
				errors++;
				return;
			end
			e = due_q.pop_front();
			checked++;
			if (got.max_speed !== e.max_speed) begin
				$error("max_speed: expected %0d, actual %0d", e.max_speed, got.max_speed);
				errors++;
			end
			if (got.min_speed !== e.min_speed) begin
				$error("min_speed: expected %0d, actual %0d", e.min_speed, got.min_speed);
				errors++;
			end
			if (got.avg_speed !== e.avg_speed) begin
				$error("avg_speed: expected %0d, actual %0d", e.avg_speed, got.avg_speed);
				errors++;
			end
			if (got.held_count !== e.held_count) begin
				$error("held_count: expected %0d, actual %0d", e.held_count, got.held_count);
				errors++;
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	swm_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_if ();
	swm_stats_if  #(.SAMPLE_BITS(SAMPLE_BITS)) stats_if ();
	swm_cfg_if                                 cfg_if ();

	sliding_window_min_max_avg_top #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_in(sample_if),
		.stats_out(stats_if),
		.cfg      (cfg_if)
	);

	wind_window_stats window_stats = new();

	bit          steady;    // no idling on either side while set
	bit          hold_req;  // receiver hold-off request, cleared by the receiver when it ends
	int unsigned cycles;
	int unsigned samples_sent;
	int unsigned size_writes;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycles, window_stats.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result receiver: random stalls, one long hold-off on request.
	initial begin
		stats_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				stats_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				stats_if.ready <= steady || ($urandom_range(99) >= 21);
			end
		end
	end

	always @(posedge clk) begin
		wind_stats_t got;
		if (arst_n && stats_if.valid && stats_if.ready) begin
			got.max_speed = stats_if.max_speed;
			got.min_speed = stats_if.min_speed;
			got.avg_speed = stats_if.avg_speed;
			got.held_count = stats_if.held_count;
			window_stats.check_stats(got);
		end
	end

	task automatic send_sample(input speed_t s);
		sample_if.valid <= 1'b1;
		sample_if.wind_speed <= s;
		@(posedge clk);
		while (!sample_if.ready)
			@(posedge clk);
		window_stats.take_sample(s);
		samples_sent++;
	endtask

	task automatic sender_gap();
		while (!steady && $urandom_range(99) < 21) begin
			sample_if.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Drop valid and wait until every result is back and the block takes input again.
	task automatic drain();
		sample_if.valid <= 1'b0;
		@(posedge clk);
		while (window_stats.pending() != 0 || !sample_if.ready)
			@(posedge clk);
	endtask

	task automatic write_window(input wsize_t v);
		drain();
		cfg_if.valid <= 1'b1;
		cfg_if.window_size <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		window_stats.set_window(v);
		size_writes++;
	endtask

	function automatic speed_t pick_speed(speed_t last);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		if (r < 30)
			return last;
		return speed_t'($urandom_range(2 ** SAMPLE_BITS - 1));
	endfunction

	function automatic wsize_t pick_window();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return wsize_t'(1);
		if (r < 28)
			return wsize_t'(MAX_WINDOW);
		if (r < 40)
			return wsize_t'($urandom_range(31, MAX_WINDOW + 1));
		return wsize_t'($urandom_range(MAX_WINDOW - 1, 2));
	endfunction

	initial begin
		speed_t      last;
		int unsigned n;
		int unsigned k;
		int unsigned done_rand;
		int unsigned phase;

		arst_n = 1'b0;
		sample_if.valid = 1'b0;
		sample_if.wind_speed = '0;
		cfg_if.valid = 1'b0;
		cfg_if.window_size = '0;
		steady = 1'b0;
		hold_req = 1'b0;
		samples_sent = 0;
		size_writes = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window of 12, driven one past full so the oldest drops out.
		send_sample('0);
		send_sample('1);
		send_sample(10'h155);
		send_sample(10'h2AA);
		send_sample(10'd1);
		send_sample(10'd1022);
		send_sample(10'd512);
		send_sample(10'd511);
		send_sample('0);
		send_sample('1);
		send_sample(10'd3);
		send_sample(10'd700);
		send_sample(10'd2);
		// Size zero behaves as one.
		write_window('0);
		send_sample(10'd5);
		send_sample(10'd6);
		// Oversized request saturates to the maximum window.
		write_window('1);
		send_sample('1);
		send_sample('0);
		send_sample(10'd1);
		write_window(wsize_t'(1));
		send_sample(10'd100);
		send_sample(10'd99);
		// Rewriting the same size still clears the window.
		write_window(wsize_t'(MAX_WINDOW));
		send_sample(10'd40);
		send_sample(10'd41);
		write_window(wsize_t'(MAX_WINDOW));
		send_sample(10'd42);

		done_rand = 0;
		phase = 0;
		last = '0;
		while (done_rand < RANDOM_ITEMS) begin
			write_window(pick_window());
			n = ($urandom_range(9) == 0) ? $urandom_range(80, 40) : $urandom_range(40, 5);
			if (phase == 1) begin
				// long receiver stall while samples keep coming
				hold_req = 1'b1;
				n = 12;
			end
			for (k = 0; k < n; k++) begin
				steady = (done_rand >= 500 && done_rand < 700);
				if (done_rand == 900)
					drain();
				sender_gap();
				last = pick_speed(last);
				send_sample(last);
				done_rand++;
			end
			phase++;
		end
		steady = 1'b0;

		drain();
		repeat (60) @(posedge clk);
		$display("Sent %0d samples across %0d window size writes (zero, oversized and full sizes)",
			samples_sent, size_writes);
		$display("Checked %0d stat results, %0d mismatches", window_stats.checked,
			window_stats.errors);
		if (window_stats.errors == 0 && window_stats.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/swm_pkg.sv
design/swm_ifs.sv
design/swm_ram.sv
design/swm_div.sv
design/sliding_window_min_max_avg_top.sv
design/swm_checker.sv
bench/tb_top.sv
